// ===== hdl/bem_pkg.sv =====
package bem_pkg;

    localparam int SAMPLE_W = 10;
    localparam int THR_W    = 10;
    localparam int TMO_W    = 16;
    localparam int TIME_W   = 32;
    localparam int STEP_W   = 23;
    localparam int ENERGY_W = 48;
    localparam int PEAKH_W  = 9;
    localparam int CFG_W    = 16;
    localparam int CNT_W    = 5;
    localparam int WIDE_W   = 64;
    localparam int FOLD_W   = 10;
    localparam int RECIP_W  = 29;
    localparam int MS_SHIFT = 38;

    // configuration register indexes
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_TIMEOUT   = 1'b1;

    localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(60);
    localparam logic [TMO_W-1:0] TIMEOUT_RST   = TMO_W'(1000);

    // ceil(2^38 / 1000): exact floor divide by 1000 for any 32-bit value
    localparam logic [RECIP_W-1:0] RECIP_MS = RECIP_W'(274877907);
    // 1023 = 2^10 - 1, divided by folding the upper bits back onto the low ten
    localparam logic [FOLD_W-1:0] FOLD_FULL = '1;

    // last count value of each serial phase
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(STEP_W - 1);
    localparam logic [CNT_W-1:0] FOLD_LAST = CNT_W'(7);

    typedef struct packed {
        logic item;          // input word taken this cycle
        logic rep_load;      // capture report fields, step_ms and the multiplicand
        logic mul_shift;     // one multiplier bit
        logic div_load_prod; // load the fold divider with the product
        logic div_fold;      // one fold step of the divide by 1023
        logic out_load;      // fill output register
    } bem_cmd_t;

    typedef struct packed {
        logic report;        // current input word closes a burst
    } bem_sts_t;

endpackage

// ===== hdl/burst_energy_meter.sv =====
// channel | direction | handshake             | payload
// --------+-----------+-----------------------+----------------------------------------
// in      | input     | in_valid / in_stall   | sample, now_ms, now_us, pause
// out     | output    | out_valid / out_stall | idle_ms, active_ms, step_ms,
//         |           |                       | energy_scaled, peak_half
// cfg     | input     | cfg_write             | cfg_index, cfg_data
//
// An input word is taken while in_stall is low; unless it closes a burst, the
// next may follow in the next cycle. A closing word holds in_stall through the
// shift-add multiply, the folding divide by 1023 and the load of the output
// register, longer while that register is full. step_ms is a reciprocal multiply.
// Reset clears the burst state, the control and the output valid, and loads the
// register defaults. A waiting output word holds up input only while a report waits.
module burst_energy_meter #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bem_pkg::SAMPLE_W-1:0] sample,
    input  logic [bem_pkg::TIME_W-1:0]   now_ms,
    input  logic [bem_pkg::TIME_W-1:0]   now_us,
    input  logic                         pause,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bem_pkg::TIME_W-1:0]   idle_ms,
    output logic [bem_pkg::TIME_W-1:0]   active_ms,
    output logic [bem_pkg::STEP_W-1:0]   step_ms,
    output logic [bem_pkg::ENERGY_W-1:0] energy_scaled,
    output logic [bem_pkg::PEAKH_W-1:0]  peak_half,
    input  logic                         cfg_write,
    input  logic                         cfg_index,
    input  logic [bem_pkg::CFG_W-1:0]    cfg_data
);
    import bem_pkg::*;

    bem_cmd_t cmd;
    bem_sts_t sts;

    bem_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    bem_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample        (sample),
        .now_ms        (now_ms),
        .now_us        (now_us),
        .pause         (pause),
        .idle_ms       (idle_ms),
        .active_ms     (active_ms),
        .step_ms       (step_ms),
        .energy_scaled (energy_scaled),
        .peak_half     (peak_half)
    );

`ifndef SYNTHESIS
    // a new word must never overwrite one still held by the receiver
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && out_stall))
        else $error("output word overwritten");

    // a closing word starts the report computation and blocks input
    a_report_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.item && sts.report) |=> in_stall)
        else $error("report did not stall input");

    // a result only appears at the end of the report computation
    a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("output word without report computation");
`endif

endmodule

// ===== hdl/bem_ctrl.sv =====
module bem_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_stall,
    input  bem_pkg::bem_sts_t sts,
    output bem_pkg::bem_cmd_t cmd,
    output logic              in_stall,
    output logic              out_valid
);
    import bem_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.item   = in_valid && !in_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.item && sts.report)
                begin
                    cmd.rep_load = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_shift = 1'b1;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == MUL_LAST)
                begin
                    cmd.div_load_prod = 1'b1;
                    cnt_next          = '0;
                    state_next        = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_fold = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == FOLD_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/bem_dp.sv =====
module bem_dp #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bem_pkg::bem_cmd_t                 cmd,
    output bem_pkg::bem_sts_t                 sts,
    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic [bem_pkg::CFG_W-1:0]         cfg_data,
    input  logic [bem_pkg::SAMPLE_W-1:0]      sample,
    input  logic [bem_pkg::TIME_W-1:0]        now_ms,
    input  logic [bem_pkg::TIME_W-1:0]        now_us,
    input  logic                              pause,
    output logic [bem_pkg::TIME_W-1:0]        idle_ms,
    output logic [bem_pkg::TIME_W-1:0]        active_ms,
    output logic [bem_pkg::STEP_W-1:0]        step_ms,
    output logic [bem_pkg::ENERGY_W-1:0]      energy_scaled,
    output logic [bem_pkg::PEAKH_W-1:0]       peak_half
);
    import bem_pkg::*;

    localparam int USED_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

    // configuration
    logic [THR_W-1:0] thr_reg;
    logic [TMO_W-1:0] tmo_reg;

    // burst state
    logic              seen_reg;
    logic [USED_W-1:0] peak_reg;
    logic [TIME_W-1:0] sum_reg;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] end_reg;
    logic [TIME_W-1:0] quiet_reg;
    logic [TIME_W-1:0] gap_reg;
    logic [TIME_W-1:0] steptot_reg;
    logic [TIME_W-1:0] last_us_reg;

    // report holding and serial arithmetic
    logic [TIME_W-1:0]  hold_idle_reg;
    logic [TIME_W-1:0]  hold_active_reg;
    logic [PEAKH_W-1:0] hold_peak_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  mplier_reg;
    logic [WIDE_W-1:0]  mcand_reg;
    logic [WIDE_W-1:0]  acc_reg, acc_next;
    logic [WIDE_W-1:0]  fold_reg, fold_next;
    logic [WIDE_W-1:0]  quo_reg, quo_next;

    // output word
    logic [TIME_W-1:0]   o_idle_reg;
    logic [TIME_W-1:0]   o_active_reg;
    logic [STEP_W-1:0]   o_step_reg;
    logic [ENERGY_W-1:0] o_energy_reg;
    logic [PEAKH_W-1:0]  o_peak_reg;

    logic [USED_W-1:0]          s_eff;
    logic [SAMPLE_W-1:0]        s_ext;
    logic [SAMPLE_W-1:0]        peak_ext;
    logic                       active;
    logic                       waiting;
    logic [TIME_W-1:0]          quiet_age;
    logic [WIDE_W-1:0]          sum_wide;
    logic [TIME_W+RECIP_W-1:0]  step_prod;
    logic [WIDE_W-1:0]          fold_hi;
    logic [WIDE_W-1:0]          quo_fix;
    logic [ENERGY_W-1:0]        energy_sat;

    assign s_eff     = sample[USED_W-1:0];
    assign s_ext     = SAMPLE_W'(s_eff);
    assign peak_ext  = SAMPLE_W'(peak_reg);
    assign active    = s_ext > thr_reg;
    assign quiet_age = now_ms - quiet_reg;
    assign waiting   = quiet_age < TIME_W'(tmo_reg);
    assign sts.report = !active && !pause && !waiting && seen_reg;

    // sum * 500 as shifts
    assign sum_wide = WIDE_W'(sum_reg);

    // step total / 1000 by reciprocal multiply
    assign step_prod = (TIME_W+RECIP_W)'(steptot_reg) * (TIME_W+RECIP_W)'(RECIP_MS);

    // x = 1024a + b = 1023a + (a + b): a goes to the quotient, a + b is folded again
    assign fold_hi   = fold_reg >> FOLD_W;
    assign fold_next = fold_hi + WIDE_W'(fold_reg[FOLD_W-1:0]);
    assign quo_next  = quo_reg + fold_hi;
    // folding leaves a remainder below 1024; 1023 is one more divisor
    assign quo_fix   = quo_reg + WIDE_W'(fold_reg == WIDE_W'(FOLD_FULL));

    assign acc_next = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;

    assign energy_sat = (|quo_fix[WIDE_W-1:ENERGY_W]) ? '1 : quo_fix[ENERGY_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RST;
            tmo_reg <= TIMEOUT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                CFG_TIMEOUT:   tmo_reg <= cfg_data[TMO_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= 1'b0;
            peak_reg    <= '0;
            sum_reg     <= '0;
            start_reg   <= '0;
            end_reg     <= '0;
            quiet_reg   <= '0;
            gap_reg     <= '0;
            steptot_reg <= '0;
            last_us_reg <= '0;
        end
        else if (cmd.item)
        begin
            if (active)
            begin
                if (s_eff > peak_reg)
                    peak_reg <= s_eff;
                if (!seen_reg)
                begin
                    start_reg <= now_ms;
                    gap_reg   <= now_ms - end_reg;
                    seen_reg  <= 1'b1;
                end
                end_reg     <= now_ms;
                quiet_reg   <= now_ms;
                sum_reg     <= sum_reg + TIME_W'(s_ext);
                steptot_reg <= steptot_reg + (now_us - last_us_reg);
            end
            else if (pause)
            begin
                quiet_reg <= now_ms;
            end
            else if (sts.report)
            begin
                seen_reg    <= 1'b0;
                peak_reg    <= '0;
                sum_reg     <= '0;
                gap_reg     <= '0;
                steptot_reg <= '0;
            end
            last_us_reg <= now_us;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rep_load)
        begin
            hold_idle_reg   <= gap_reg;
            hold_active_reg <= end_reg - start_reg;
            hold_peak_reg   <= peak_ext[SAMPLE_W-1:1];
            step_reg        <= step_prod[MS_SHIFT +: STEP_W];
            mplier_reg      <= step_prod[MS_SHIFT +: STEP_W];
            mcand_reg       <= (sum_wide << 9) - (sum_wide << 3) - (sum_wide << 2);
            acc_reg         <= '0;
        end
        else if (cmd.mul_shift)
        begin
            acc_reg    <= acc_next;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end

        if (cmd.div_load_prod)
        begin
            fold_reg <= acc_next;
            quo_reg  <= '0;
        end
        else if (cmd.div_fold)
        begin
            fold_reg <= fold_next;
            quo_reg  <= quo_next;
        end

        if (cmd.out_load)
        begin
            o_idle_reg   <= hold_idle_reg;
            o_active_reg <= hold_active_reg;
            o_step_reg   <= step_reg;
            o_energy_reg <= energy_sat;
            o_peak_reg   <= hold_peak_reg;
        end
    end

    assign idle_ms       = o_idle_reg;
    assign active_ms     = o_active_reg;
    assign step_ms       = o_step_reg;
    assign energy_scaled = o_energy_reg;
    assign peak_half     = o_peak_reg;

endmodule
